FILE: rtl/msr_pkg.sv
// shared types, constants and helpers for the multipart snapshot reassembler
package msr_pkg;

  localparam int unsigned MAX_BYTES_DEF   = 4096;
  localparam int unsigned CHUNK_BYTES_DEF = 1024;

  localparam int unsigned SEQ_W    = 20;
  localparam int unsigned BYTES_W  = 14;
  localparam int unsigned ECNT_W   = 14;
  localparam int unsigned PART_W   = 4;
  localparam int unsigned TAIL_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned COPY_W   = 13;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned FBYTES_W = 13;
  localparam int unsigned EBYTES_W = 13;
  localparam int unsigned MAX_PARTS = 9;
  localparam int unsigned END_W    = 18;

  typedef enum logic [STATUS_W-1:0] {
    ST_REJECT   = 3'd0,
    ST_STALE    = 3'd1,
    ST_DUPE     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_STORED   = 3'd4,
    ST_COMPLETE = 3'd5,
    ST_MISMATCH = 3'd6
  } msr_status_t;

  typedef struct packed {
    logic               header_valid;
    logic [SEQ_W-1:0]   sequence_req;
    logic [BYTES_W-1:0] part_bytes;
    logic [ECNT_W-1:0]  entry_count;
    logic [PART_W-1:0]  part_index;
    logic [PART_W-1:0]  part_total;
    logic [TAIL_W-1:0]  tail_bytes;
  } msr_req_t;

  typedef struct packed {
    msr_status_t         status;
    logic [OFF_W-1:0]    dest_offset;
    logic [COPY_W-1:0]   copy_bytes;
    logic                stale;
    logic [CNT_W-1:0]    dupe_count;
    logic [CNT_W-1:0]    torn_count;
    logic [CNT_W-1:0]    gap_count;
    logic [CNT_W-1:0]    frame_count;
    logic [FBYTES_W-1:0] frame_bytes;
  } msr_result_t;

  // mask with the low n bits set, n up to MAX_PARTS
  function automatic logic [MAX_PARTS-1:0] part_mask(input logic [PART_W-1:0] n);
    logic [MAX_PARTS:0] t;
    t = ({{MAX_PARTS{1'b0}}, 1'b1} << n) - {{MAX_PARTS{1'b0}}, 1'b1};
    return t[MAX_PARTS-1:0];
  endfunction

endpackage

FILE: rtl/msr_assembler.sv
// assembly state and per-request decision logic
module msr_assembler #(
  parameter int unsigned MAX_BYTES   = msr_pkg::MAX_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = msr_pkg::CHUNK_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  msr_pkg::msr_req_t                   req,
  input  logic [msr_pkg::ECNT_W-1:0]          expected_count,
  input  logic [msr_pkg::EBYTES_W-1:0]        expected_bytes,
  output msr_pkg::msr_result_t                result
);
  import msr_pkg::*;

  localparam int unsigned ABW = $clog2(MAX_BYTES + 1);

  logic [SEQ_W-1:0]     last_seq_r, last_seq_nxt;
  logic                 have_last_r, have_last_nxt;
  logic [SEQ_W-1:0]     asm_seq_r, asm_seq_nxt;
  logic [PART_W-1:0]    asm_total_r, asm_total_nxt;
  logic [MAX_PARTS-1:0] seen_mask_r, seen_mask_nxt;
  logic [ABW-1:0]       asm_bytes_r, asm_bytes_nxt;
  logic [BYTES_W-1:0]   chunk_size_r, chunk_size_nxt;
  logic                 stale_r, stale_nxt;
  logic [CNT_W-1:0]     dupes_r, dupes_nxt;
  logic [CNT_W-1:0]     torn_r, torn_nxt;
  logic [CNT_W-1:0]     gaps_r, gaps_nxt;
  logic [CNT_W-1:0]     frames_r, frames_nxt;
  logic [ABW-1:0]       last_frame_r, last_frame_nxt;

  logic                 reject;
  logic                 new_asm;
  logic                 restart;
  logic [MAX_PARTS-1:0] mask1, mask2, full_new;
  logic [ABW-1:0]       bytes1, bytes2;
  logic [BYTES_W-1:0]   chunk0, chunk1;
  logic [END_W-1:0]     dst, end_pos;
  msr_status_t          status;
  logic [OFF_W-1:0]     off;
  logic [COPY_W-1:0]    len;

  always_comb begin
    last_seq_nxt   = last_seq_r;
    have_last_nxt  = have_last_r;
    asm_seq_nxt    = asm_seq_r;
    asm_total_nxt  = asm_total_r;
    seen_mask_nxt  = seen_mask_r;
    asm_bytes_nxt  = asm_bytes_r;
    chunk_size_nxt = chunk_size_r;
    stale_nxt      = stale_r;
    dupes_nxt      = dupes_r;
    torn_nxt       = torn_r;
    gaps_nxt       = gaps_r;
    frames_nxt     = frames_r;
    last_frame_nxt = last_frame_r;
    status         = ST_REJECT;
    off            = '0;
    len            = '0;

    reject = !req.header_valid || (req.part_bytes == '0) || (req.entry_count == '0) ||
             (req.part_total == '0) || (req.part_total > PART_W'(MAX_PARTS)) ||
             (req.part_index >= req.part_total) ||
             (TAIL_W'(req.part_bytes) > req.tail_bytes) ||
             (req.part_bytes > BYTES_W'(MAX_BYTES));

    new_asm = (asm_seq_r != req.sequence_req) || (asm_total_r != req.part_total);
    mask1   = new_asm ? '0 : seen_mask_r;
    bytes1  = new_asm ? '0 : asm_bytes_r;
    chunk0  = new_asm ? BYTES_W'(CHUNK_BYTES) : chunk_size_r;
    restart = ((req.part_index + PART_W'(1)) < req.part_total) && (req.part_bytes != chunk0);
    if (restart) begin
      mask1  = '0;
      bytes1 = '0;
    end
    chunk1   = restart ? req.part_bytes : chunk0;
    full_new = part_mask(req.part_total);
    dst      = END_W'(req.part_index) * END_W'(chunk1);
    end_pos  = dst + END_W'(req.part_bytes);
    mask2    = mask1 | ({{(MAX_PARTS-1){1'b0}}, 1'b1} << req.part_index);
    bytes2   = (end_pos > END_W'(bytes1)) ? ABW'(end_pos) : bytes1;

    if (reject) begin
      status = ST_REJECT;
    end else if (req.entry_count != expected_count) begin
      stale_nxt = 1'b1;
      status    = ST_STALE;
    end else begin
      stale_nxt = 1'b0;
      if (have_last_r && (req.sequence_req == last_seq_r)) begin
        dupes_nxt = dupes_r + CNT_W'(1);
        status    = ST_DUPE;
      end else begin
        if (new_asm && (seen_mask_r != '0) && (seen_mask_r != part_mask(asm_total_r))) begin
          torn_nxt = torn_r + CNT_W'(1);
        end
        asm_seq_nxt    = req.sequence_req;
        asm_total_nxt  = req.part_total;
        seen_mask_nxt  = mask1;
        asm_bytes_nxt  = bytes1;
        chunk_size_nxt = chunk1;
        if (end_pos > END_W'(MAX_BYTES)) begin
          status = ST_RANGE;
        end else begin
          off           = dst[OFF_W-1:0];
          len           = req.part_bytes[COPY_W-1:0];
          seen_mask_nxt = mask2;
          asm_bytes_nxt = bytes2;
          if (mask2 != full_new) begin
            status = ST_STORED;
          end else if (END_W'(bytes2) != END_W'(expected_bytes)) begin
            stale_nxt     = 1'b1;
            seen_mask_nxt = '0;
            status        = ST_MISMATCH;
          end else begin
            if (have_last_r &&
                ({1'b0, req.sequence_req} > ({1'b0, last_seq_r} + (SEQ_W+1)'(1)))) begin
              gaps_nxt = gaps_r + CNT_W'(req.sequence_req - last_seq_r - SEQ_W'(1));
            end
            last_seq_nxt   = req.sequence_req;
            have_last_nxt  = 1'b1;
            seen_mask_nxt  = '0;
            frames_nxt     = frames_r + CNT_W'(1);
            last_frame_nxt = bytes2;
            status         = ST_COMPLETE;
          end
        end
      end
    end

    result.status      = status;
    result.dest_offset = off;
    result.copy_bytes  = len;
    result.stale       = stale_nxt;
    result.dupe_count  = dupes_nxt;
    result.torn_count  = torn_nxt;
    result.gap_count   = gaps_nxt;
    result.frame_count = frames_nxt;
    result.frame_bytes = FBYTES_W'(last_frame_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r   <= '0;
      have_last_r  <= 1'b0;
      asm_seq_r    <= '0;
      asm_total_r  <= '0;
      seen_mask_r  <= '0;
      asm_bytes_r  <= '0;
      chunk_size_r <= BYTES_W'(CHUNK_BYTES);
      stale_r      <= 1'b0;
      dupes_r      <= '0;
      torn_r       <= '0;
      gaps_r       <= '0;
      frames_r     <= '0;
      last_frame_r <= '0;
    end else if (advance) begin
      last_seq_r   <= last_seq_nxt;
      have_last_r  <= have_last_nxt;
      asm_seq_r    <= asm_seq_nxt;
      asm_total_r  <= asm_total_nxt;
      seen_mask_r  <= seen_mask_nxt;
      asm_bytes_r  <= asm_bytes_nxt;
      chunk_size_r <= chunk_size_nxt;
      stale_r      <= stale_nxt;
      dupes_r      <= dupes_nxt;
      torn_r       <= torn_nxt;
      gaps_r       <= gaps_nxt;
      frames_r     <= frames_nxt;
      last_frame_r <= last_frame_nxt;
    end
  end

endmodule

FILE: rtl/multipart_snapshot_reassembler_top.sv
// top level: config registers, request register, assembler and result register
// an accepted request is held in the request register, then its result is registered
// throughput: one request per cycle unless output stalls, set by the combinational decision
// the request register refills while the result register drains, so a waiting result
// does not stop input unless both stages are full
// reset (rst_n low, synchronous) clears config, counters, assembly state and both stages
module multipart_snapshot_reassembler_top #(
  parameter int unsigned MAX_BYTES   = msr_pkg::MAX_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = msr_pkg::CHUNK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_header_valid,
  input  logic [msr_pkg::SEQ_W-1:0]      in_sequence_req,
  input  logic [msr_pkg::BYTES_W-1:0]    in_part_bytes,
  input  logic [msr_pkg::ECNT_W-1:0]     in_entry_count,
  input  logic [msr_pkg::PART_W-1:0]     in_part_index,
  input  logic [msr_pkg::PART_W-1:0]     in_part_total,
  input  logic [msr_pkg::TAIL_W-1:0]     in_tail_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [msr_pkg::STATUS_W-1:0]   out_status,
  output logic [msr_pkg::OFF_W-1:0]      out_dest_offset,
  output logic [msr_pkg::COPY_W-1:0]     out_copy_bytes,
  output logic                           out_stale,
  output logic [msr_pkg::CNT_W-1:0]      out_dupe_count,
  output logic [msr_pkg::CNT_W-1:0]      out_torn_count,
  output logic [msr_pkg::CNT_W-1:0]      out_gap_count,
  output logic [msr_pkg::CNT_W-1:0]      out_frame_count,
  output logic [msr_pkg::FBYTES_W-1:0]   out_frame_bytes
);
  import msr_pkg::*;

  localparam logic REG_EXPECTED_COUNT = 1'b0;
  localparam logic REG_EXPECTED_BYTES = 1'b1;

  logic [ECNT_W-1:0]   expected_count_r;
  logic [EBYTES_W-1:0] expected_bytes_r;
  logic                cfg_write;
  logic                reg_sel;

  logic                in_v_r;
  msr_req_t            in_r;
  logic                out_v_r;
  msr_result_t         out_r;
  logic                advance;
  msr_result_t         result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_count_r <= '0;
      expected_bytes_r <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_EXPECTED_COUNT: expected_count_r <= pwdata[ECNT_W-1:0];
        REG_EXPECTED_BYTES: expected_bytes_r <= pwdata[EBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EXPECTED_COUNT: prdata = 32'(expected_count_r);
      REG_EXPECTED_BYTES: prdata = 32'(expected_bytes_r);
      default:            prdata = '0;
    endcase
  end

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r.header_valid <= in_header_valid;
      in_r.sequence_req <= in_sequence_req;
      in_r.part_bytes   <= in_part_bytes;
      in_r.entry_count  <= in_entry_count;
      in_r.part_index   <= in_part_index;
      in_r.part_total   <= in_part_total;
      in_r.tail_bytes   <= in_tail_bytes;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  msr_assembler #(
    .MAX_BYTES   (MAX_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_assembler (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .req            (in_r),
    .expected_count (expected_count_r),
    .expected_bytes (expected_bytes_r),
    .result         (result)
  );

  assign out_valid       = out_v_r;
  assign out_status      = out_r.status;
  assign out_dest_offset = out_r.dest_offset;
  assign out_copy_bytes  = out_r.copy_bytes;
  assign out_stale       = out_r.stale;
  assign out_dupe_count  = out_r.dupe_count;
  assign out_torn_count  = out_r.torn_count;
  assign out_gap_count   = out_r.gap_count;
  assign out_frame_count = out_r.frame_count;
  assign out_frame_bytes = out_r.frame_bytes;

endmodule

FILE: verif/multipart_snapshot_reassembler_top_test.sv
// testbench for multipart_snapshot_reassembler_top with directed and random requests
module multipart_snapshot_reassembler_top_test;
  import msr_pkg::*;

  localparam logic [2:0] REG_EXPECTED_COUNT = 3'd0;
  localparam logic [2:0] REG_EXPECTED_BYTES = 3'd4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_header_valid = 1'b0;
  logic [SEQ_W-1:0] in_sequence_req = '0;
  logic [BYTES_W-1:0] in_part_bytes = '0;
  logic [ECNT_W-1:0] in_entry_count = '0;
  logic [PART_W-1:0] in_part_index = '0;
  logic [PART_W-1:0] in_part_total = '0;
  logic [TAIL_W-1:0] in_tail_bytes = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [OFF_W-1:0] out_dest_offset;
  logic [COPY_W-1:0] out_copy_bytes;
  logic out_stale;
  logic [CNT_W-1:0] out_dupe_count;
  logic [CNT_W-1:0] out_torn_count;
  logic [CNT_W-1:0] out_gap_count;
  logic [CNT_W-1:0] out_frame_count;
  logic [FBYTES_W-1:0] out_frame_bytes;

  multipart_snapshot_reassembler_top DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_header_valid(in_header_valid), .in_sequence_req(in_sequence_req),
    .in_part_bytes(in_part_bytes), .in_entry_count(in_entry_count),
    .in_part_index(in_part_index), .in_part_total(in_part_total),
    .in_tail_bytes(in_tail_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_dest_offset(out_dest_offset),
    .out_copy_bytes(out_copy_bytes), .out_stale(out_stale),
    .out_dupe_count(out_dupe_count), .out_torn_count(out_torn_count),
    .out_gap_count(out_gap_count), .out_frame_count(out_frame_count),
    .out_frame_bytes(out_frame_bytes)
  );

  // predictor state
  int unsigned cfg_count = 0;
  int unsigned cfg_bytes = 0;
  int unsigned done_seq = 0;
  bit done_valid = 1'b0;
  int unsigned build_seq = 0;
  int unsigned build_total = 0;
  int unsigned build_mask = 0;
  int unsigned build_bytes = 0;
  int unsigned build_chunk = CHUNK_BYTES_DEF;
  bit stale_now = 1'b0;
  logic [31:0] dupes_seen = '0;
  logic [31:0] torn_seen = '0;
  logic [31:0] gaps_seen = '0;
  logic [31:0] frames_seen = '0;
  int unsigned frame_size = 0;

  msr_result_t part_verdicts[$];
  msr_result_t verdict;
  int unsigned sent_parts = 0;
  int unsigned faults = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [SEQ_W-1:0] frame_seq = '0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic msr_result_t judge_part(input msr_req_t r);
    int unsigned seq, vb, cnt, pt, np, tail, full, dst, off, len;
    msr_status_t st;
    msr_result_t res;
    seq = r.sequence_req;
    vb = r.part_bytes;
    cnt = r.entry_count;
    pt = r.part_index;
    np = r.part_total;
    tail = r.tail_bytes;
    off = 0;
    len = 0;
    if (!r.header_valid || vb == 0 || cnt == 0 || np == 0 || np > MAX_PARTS || pt >= np ||
        vb > tail || vb > MAX_BYTES_DEF) begin
      st = ST_REJECT;
    end else if (cnt != cfg_count) begin
      stale_now = 1'b1;
      st = ST_STALE;
    end else begin
      stale_now = 1'b0;
      if (done_valid && seq == done_seq) begin
        dupes_seen = dupes_seen + 1;
        st = ST_DUPE;
      end else begin
        full = (32'd1 << build_total) - 1;
        if (build_seq != seq || build_total != np) begin
          if (build_mask != 0 && build_mask != full) torn_seen = torn_seen + 1;
          build_seq = seq;
          build_total = np;
          build_mask = 0;
          build_bytes = 0;
          build_chunk = CHUNK_BYTES_DEF;
        end
        full = (32'd1 << np) - 1;
        if (pt + 1 < np && vb != build_chunk) begin
          build_mask = 0;
          build_bytes = 0;
          build_chunk = vb;
        end
        dst = pt * build_chunk;
        if (dst + vb > MAX_BYTES_DEF) begin
          st = ST_RANGE;
        end else begin
          build_mask = build_mask | (32'd1 << pt);
          if (dst + vb > build_bytes) build_bytes = dst + vb;
          off = dst;
          len = vb;
          if (build_mask != full) begin
            st = ST_STORED;
          end else if (build_bytes != cfg_bytes) begin
            stale_now = 1'b1;
            build_mask = 0;
            st = ST_MISMATCH;
          end else begin
            if (done_valid && seq > done_seq + 1) gaps_seen = gaps_seen + (seq - done_seq - 1);
            done_seq = seq;
            done_valid = 1'b1;
            build_mask = 0;
            frames_seen = frames_seen + 1;
            frame_size = build_bytes;
            st = ST_COMPLETE;
          end
        end
      end
    end
    res.status = st;
    res.dest_offset = off[OFF_W-1:0];
    res.copy_bytes = len[COPY_W-1:0];
    res.stale = stale_now;
    res.dupe_count = dupes_seen;
    res.torn_count = torn_seen;
    res.gap_count = gaps_seen;
    res.frame_count = frames_seen;
    res.frame_bytes = frame_size[FBYTES_W-1:0];
    return res;
  endfunction

  function automatic msr_req_t part_hdr(input int unsigned hv, input int unsigned seq,
                                        input int unsigned vb, input int unsigned cnt,
                                        input int unsigned pt, input int unsigned np,
                                        input int unsigned tail);
    msr_req_t r;
    r.header_valid = (hv != 0);
    r.sequence_req = SEQ_W'(seq);
    r.part_bytes = BYTES_W'(vb);
    r.entry_count = ECNT_W'(cnt);
    r.part_index = PART_W'(pt);
    r.part_total = PART_W'(np);
    r.tail_bytes = TAIL_W'(tail);
    return r;
  endfunction

  // the store of expected results is filled at the edge where a request is accepted
  task automatic send_part(input msr_req_t r);
    msr_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_header_valid <= r.header_valid;
    in_sequence_req <= r.sequence_req;
    in_part_bytes <= r.part_bytes;
    in_entry_count <= r.entry_count;
    in_part_index <= r.part_index;
    in_part_total <= r.part_total;
    in_tail_bytes <= r.tail_bytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = judge_part(r);
    part_verdicts.push_back(res);
    sent_parts++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (part_verdicts.size() == 0) begin
        $error("result with no request pending");
        faults++;
      end else begin
        verdict = part_verdicts.pop_front();
        if (out_status !== verdict.status) begin
          $error("status expected %0d actual %0d", verdict.status, out_status);
          faults++;
        end
        if (out_dest_offset !== verdict.dest_offset) begin
          $error("dest_offset expected %0d actual %0d", verdict.dest_offset, out_dest_offset);
          faults++;
        end
        if (out_copy_bytes !== verdict.copy_bytes) begin
          $error("copy_bytes expected %0d actual %0d", verdict.copy_bytes, out_copy_bytes);
          faults++;
        end
        if (out_stale !== verdict.stale) begin
          $error("stale expected %0d actual %0d", verdict.stale, out_stale);
          faults++;
        end
        if (out_dupe_count !== verdict.dupe_count) begin
          $error("dupe_count expected %0d actual %0d", verdict.dupe_count, out_dupe_count);
          faults++;
        end
        if (out_torn_count !== verdict.torn_count) begin
          $error("torn_count expected %0d actual %0d", verdict.torn_count, out_torn_count);
          faults++;
        end
        if (out_gap_count !== verdict.gap_count) begin
          $error("gap_count expected %0d actual %0d", verdict.gap_count, out_gap_count);
          faults++;
        end
        if (out_frame_count !== verdict.frame_count) begin
          $error("frame_count expected %0d actual %0d", verdict.frame_count, out_frame_count);
          faults++;
        end
        if (out_frame_bytes !== verdict.frame_bytes) begin
          $error("frame_bytes expected %0d actual %0d", verdict.frame_bytes, out_frame_bytes);
          faults++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (addr)
      REG_EXPECTED_COUNT: begin
        cfg_count = data[ECNT_W-1:0];
        if (prdata !== 32'(data[ECNT_W-1:0])) begin
          $error("expected_count expected %0d actual %0d", data[ECNT_W-1:0], prdata);
          faults++;
        end
      end
      REG_EXPECTED_BYTES: begin
        cfg_bytes = data[EBYTES_W-1:0];
        if (prdata !== 32'(data[EBYTES_W-1:0])) begin
          $error("expected_bytes expected %0d actual %0d", data[EBYTES_W-1:0], prdata);
          faults++;
        end
      end
      default: ;
    endcase
  endtask

  // registers change only with the pipeline empty
  task automatic program_limits(input int unsigned count, input int unsigned nbytes);
    while (part_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_EXPECTED_COUNT, count);
    write_reg(REG_EXPECTED_BYTES, nbytes);
  endtask

  task automatic run_traffic(input int unsigned target);
    msr_req_t parts[MAX_PARTS];
    msr_req_t tmp;
    msr_req_t r;
    int unsigned np, c, last_len, pick, j, k, skip, vb, goal;
    logic [SEQ_W-1:0] seq;
    goal = sent_parts + target;
    while (sent_parts < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        k = $urandom_range(99);
        if (k < 6) seq = frame_seq;
        else if (k < 16) seq = SEQ_W'(frame_seq + $urandom_range(2, 40));
        else seq = frame_seq + SEQ_W'(1);
        frame_seq = seq;
        np = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_PARTS) : $urandom_range(1, 4);
        if (cfg_bytes != 0 && np > cfg_bytes) np = cfg_bytes;
        if (np == 1) c = 0;
        else if (cfg_bytes > (np - 1) * 1024 && $urandom_range(3) == 0) c = 1024;
        else if (cfg_bytes > np - 1) c = $urandom_range(1, (cfg_bytes - 1) / (np - 1));
        else c = $urandom_range(1, 300);
        if (cfg_bytes > (np - 1) * c) last_len = cfg_bytes - (np - 1) * c;
        else last_len = $urandom_range(1, 300);
        for (j = 0; j < np; j++) begin
          vb = (j + 1 == np) ? last_len : c;
          r.header_valid = ($urandom_range(49) != 0);
          r.sequence_req = seq;
          r.part_bytes = BYTES_W'(vb);
          r.entry_count = ECNT_W'(($urandom_range(39) == 0) ? $urandom_range(0, 16383)
                                                              : cfg_count);
          r.part_index = PART_W'(j);
          r.part_total = PART_W'(np);
          r.tail_bytes = TAIL_W'(($urandom_range(9) == 0) ? $urandom_range(vb, 65535)
                                                            : vb + $urandom_range(0, 40));
          parts[j] = r;
        end
        if ($urandom_range(4) == 0) begin
          for (j = np - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = parts[j];
            parts[j] = parts[k];
            parts[k] = tmp;
          end
        end
        skip = (np > 1 && $urandom_range(9) == 0) ? $urandom_range(0, np - 1) : MAX_PARTS;
        for (j = 0; j < np; j++) begin
          if (j != skip) send_part(parts[j]);
        end
      end else begin
        r.header_valid = ($urandom_range(1) == 1);
        r.sequence_req = SEQ_W'($urandom_range(0, 20'hFFFFF));
        r.part_bytes = BYTES_W'(($urandom_range(3) == 0) ? $urandom_range(0, 16383)
                                                         : $urandom_range(0, 4200));
        r.entry_count = ECNT_W'(($urandom_range(1) == 1) ? cfg_count
                                                         : $urandom_range(0, 16383));
        r.part_index = PART_W'($urandom_range(0, 15));
        r.part_total = PART_W'($urandom_range(0, 15));
        r.tail_bytes = TAIL_W'($urandom_range(0, 65535));
        send_part(r);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_header_checks_and_cases;
    send_idle_pct = 19;
    recv_idle_pct = 78;
    program_limits(7, 2500);
    send_part(part_hdr(0, 1, 100, 7, 0, 1, 100));
    send_part(part_hdr(1, 1, 0, 7, 0, 1, 100));
    send_part(part_hdr(1, 1, 100, 0, 0, 1, 100));
    send_part(part_hdr(1, 1, 100, 7, 0, 0, 100));
    send_part(part_hdr(1, 1, 100, 7, 0, 10, 100));
    send_part(part_hdr(1, 1, 100, 7, 15, 15, 100));
    send_part(part_hdr(1, 1, 100, 7, 9, 9, 100));
    send_part(part_hdr(1, 1, 100, 7, 0, 1, 99));
    send_part(part_hdr(1, 1, 5000, 7, 0, 1, 65535));
    send_part(part_hdr(1, 1, 16383, 7, 0, 1, 65535));
    send_part(part_hdr(1, 1, 100, 8, 0, 1, 100));
    send_part(part_hdr(1, 1, 2500, 7, 0, 1, 2500));
    send_part(part_hdr(1, 1, 2500, 7, 0, 1, 2500));
    send_part(part_hdr(1, 2, 1024, 7, 0, 3, 1024));
    // new sequence tears the open assembly and a short chunk restarts it
    send_part(part_hdr(1, 3, 600, 7, 0, 2, 600));
    send_part(part_hdr(1, 3, 1900, 7, 1, 2, 4000));
    send_part(part_hdr(1, 5, 1024, 7, 8, 9, 1024));
    send_part(part_hdr(1, 5, 100, 7, 0, 2, 100));
    send_part(part_hdr(1, 5, 50, 7, 1, 2, 50));
    send_part(part_hdr(1, 20'hFFFFF, 4096, 7, 0, 1, 65535));
    send_part(part_hdr(1, 20'hFFFFF, 100, 16383, 0, 1, 100));
    send_part(part_hdr(1, 1000000, 2500, 7, 0, 1, 2500));
    send_part(part_hdr(1, 0, 2500, 7, 0, 1, 2500));
    in_valid <= 1'b0;
  endtask

  task automatic test_zero_limits;
    program_limits(0, 0);
    run_traffic(15);
  endtask

  task automatic test_sender_light_receiver_heavy;
    send_idle_pct = 19;
    recv_idle_pct = 78;
    program_limits(9999, MAX_BYTES_DEF);
    run_traffic(420);
  endtask

  task automatic test_sender_heavy_receiver_light;
    send_idle_pct = 78;
    recv_idle_pct = 19;
    program_limits($urandom_range(1, 9999), $urandom_range(64, MAX_BYTES_DEF));
    run_traffic(420);
  endtask

  task automatic test_no_idle;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_limits($urandom_range(1, 9999), $urandom_range(1, MAX_BYTES_DEF));
    run_traffic(430);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_header_checks_and_cases();
    test_zero_limits();
    test_sender_light_receiver_heavy();
    test_sender_heavy_receiver_light();
    test_no_idle();
    while (part_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0 && part_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msr_pkg.sv
rtl/msr_assembler.sv
rtl/multipart_snapshot_reassembler_top.sv
verif/multipart_snapshot_reassembler_top_test.sv
